FILE: design/mipbox_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipbox_pkg
// Shared constants, types and width helpers for the tiled mip box downsampler.
// ----------------------------------------------------------------------------
package mipbox_pkg;

  localparam int CHAN_NUM   = 4;
  localparam int CHAN_W     = 8;
  localparam int PAIR_W     = 9;
  localparam int SUM_W      = 10;
  localparam int ADDR_W     = 26;
  localparam int SIZE_W     = 13;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 26;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  localparam int MAX_HEIGHT = 4096;
  localparam int H_W        = $clog2(MAX_HEIGHT + 1);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int OY_W       = $clog2(MAX_HEIGHT / 2);

  localparam int QUEUE_DEPTH = 4;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int TILE_SIZE_DEF = 8;
  localparam int CHANNELS_DEF  = 4;

  typedef enum logic [CFG_AW-1:0] {
    REG_SRC_WIDTH    = 2'd0,
    REG_SRC_HEIGHT   = 2'd1,
    REG_LEVEL_OFFSET = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic emit;
    logic last;
  } mb_ctl_t;

  typedef logic [CHAN_NUM-1:0][PAIR_W-1:0] pair_vec_t;
  typedef logic [CHAN_NUM-1:0][CHAN_W-1:0] pix_vec_t;

  // bits needed to index n entries
  function automatic int bits_for(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // queue item: ctl, line index, pair sums, tile row, tile column, oy in tile, ox in tile
  function automatic int item_w(input int max_width, input int tile);
    return $bits(mb_ctl_t) + 2 * bits_for(max_width / 2) + CHAN_NUM * PAIR_W + OY_W
           + 2 * bits_for(tile);
  endfunction

endpackage

FILE: design/tiled_mip_box_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_mip_box_downsample
// 2x2 box downsampler that builds the next mip level with tiled addresses.
// ----------------------------------------------------------------------------
// path: the bottom-right pixel's item passes a 4-entry queue between front
// and back, stage one, stage two, output register; throughput: one pixel
// per cycle while the queue has room, set by the single line buffer port,
// used once per horizontal pair (write on even rows, read on odd rows)
// reset: positions, queue, pipeline valids cleared; sizes back to 2x2,
// offset 0; the line buffer is not cleared and is written before it is read
module tiled_mip_box_downsample #(
  parameter int MAX_WIDTH = mipbox_pkg::MAX_WIDTH_DEF,
  parameter int TILE_SIZE = mipbox_pkg::TILE_SIZE_DEF,
  parameter int CHANNELS  = mipbox_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // chan0, chan1, chan2, chan3
  input  logic [mipbox_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // avg0, avg1, avg2, avg3, dest_addr, zero fill
  output logic [mipbox_pkg::OUT_DATA_W-1:0] m_tdata,
  // level_done
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [mipbox_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [mipbox_pkg::CFG_DW-1:0]     cfg_data
);
  import mipbox_pkg::*;

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int ITEM_W = item_w(MAX_WIDTH, TILE_SIZE);

  logic [SIZE_W-1:0] src_width;
  logic [SIZE_W-1:0] src_height;
  logic [ADDR_W-1:0] level_offset;

  logic [WW-1:0]     w;
  logic [H_W-1:0]    h;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [ITEM_W-1:0] q_din;
  logic [ITEM_W-1:0] q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= SIZE_W'(2);
      src_height   <= SIZE_W'(2);
      level_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SRC_WIDTH:    src_width    <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT:   src_height   <= cfg_data[SIZE_W-1:0];
        REG_LEVEL_OFFSET: level_offset <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, large sizes saturate
  always_comb begin
    if (src_width == '0) begin
      w = WW'(1);
    end else if (32'(src_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(src_width);
    end
    if (src_height == '0) begin
      h = H_W'(1);
    end else if (32'(src_height) > MAX_HEIGHT) begin
      h = H_W'(MAX_HEIGHT);
    end else begin
      h = H_W'(src_height);
    end
  end

  mipbox_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .TILE_SIZE (TILE_SIZE),
    .CHANNELS  (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .w        (w),
    .h        (h),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_din)
  );

  mipbox_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  mipbox_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .TILE_SIZE (TILE_SIZE),
    .CHANNELS  (CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_item       (q_dout),
    .q_pop        (q_pop),
    .w            (w),
    .level_offset (level_offset),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

FILE: design/mipbox_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipbox_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mipbox_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic                            re,
  input  logic [mipbox_pkg::bits_for(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]                wdata,
  output logic [WIDTH-1:0]                rdata
);
  import mipbox_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/mipbox_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipbox_front
// Accepts source pixels, tracks the raster and tile position and classifies
// each horizontal pair as a line buffer write or an averaged output.
// ----------------------------------------------------------------------------
module mipbox_front #(
  parameter int MAX_WIDTH = mipbox_pkg::MAX_WIDTH_DEF,
  parameter int TILE_SIZE = mipbox_pkg::TILE_SIZE_DEF,
  parameter int CHANNELS  = mipbox_pkg::CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [mipbox_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]         w,
  input  logic [mipbox_pkg::H_W-1:0]             h,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [mipbox_pkg::item_w(MAX_WIDTH, TILE_SIZE)-1:0] q_item
);
  import mipbox_pkg::*;

  localparam int X_W   = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int IDX_W = bits_for(MAX_WIDTH / 2);
  localparam int TI_W  = bits_for(TILE_SIZE);

  logic [X_W-1:0]   x;
  logic [Y_W-1:0]   y;
  logic [TI_W-1:0]  ox_in;
  logic [TI_W-1:0]  oy_in;
  logic [IDX_W-1:0] tile_col;
  logic [OY_W-1:0]  tile_row;
  pix_vec_t         col_pix;

  pix_vec_t   px;
  pair_vec_t  pair;
  mb_ctl_t    ctl;
  logic       accept;
  logic       in_region;
  logic       x_last;
  logic       y_last;
  logic [WW-1:0]  ew;
  logic [H_W-1:0] eh;
  logic [IDX_W-1:0] idx;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    for (int c = 0; c < CHAN_NUM; c++) begin
      px[c]   = (c < CHANNELS) ? s_tdata[c*CHAN_W +: CHAN_W] : '0;
      pair[c] = {1'b0, col_pix[c]} + {1'b0, px[c]};
    end
  end

  assign ew        = {w[WW-1:1], 1'b0};
  assign eh        = {h[H_W-1:1], 1'b0};
  assign in_region = (WW'(x) < ew) && (H_W'(y) < eh);
  assign x_last    = WW'(x) >= (w - WW'(1));
  assign y_last    = H_W'(y) >= (h - H_W'(1));
  assign idx       = IDX_W'(x >> 1);

  assign ctl.emit = y[0];
  assign ctl.last = (WW'(x) == (ew - WW'(1))) && (H_W'(y) == (eh - H_W'(1)));

  assign q_push = accept && in_region && x[0];
  assign q_item = {ctl, idx, pair, tile_row, tile_col, oy_in, ox_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      x        <= '0;
      y        <= '0;
      ox_in    <= '0;
      oy_in    <= '0;
      tile_col <= '0;
      tile_row <= '0;
      col_pix  <= '0;
    end else if (accept) begin
      if (in_region && !x[0]) begin
        col_pix <= px;
      end
      if (x_last) begin
        x        <= '0;
        ox_in    <= '0;
        tile_col <= '0;
        if (y_last) begin
          y        <= '0;
          oy_in    <= '0;
          tile_row <= '0;
        end else begin
          y <= y + Y_W'(1);
          if (y[0]) begin
            if (oy_in == TI_W'(TILE_SIZE - 1)) begin
              oy_in    <= '0;
              tile_row <= tile_row + OY_W'(1);
            end else begin
              oy_in <= oy_in + TI_W'(1);
            end
          end
        end
      end else begin
        x <= x + X_W'(1);
        if (x[0]) begin
          if (ox_in == TI_W'(TILE_SIZE - 1)) begin
            ox_in    <= '0;
            tile_col <= tile_col + IDX_W'(1);
          end else begin
            ox_in <= ox_in + TI_W'(1);
          end
        end
      end
    end
  end

endmodule

FILE: design/mipbox_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipbox_queue
// Short register FIFO between the classifying front and the back pipeline.
// ----------------------------------------------------------------------------
module mipbox_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = mipbox_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import mipbox_pkg::*;

  localparam int PTR_W = bits_for(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (rd_ptr == wr_ptr))
    else $error("queue pointers disagree with count");

endmodule

FILE: design/mipbox_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipbox_back
// Drains queued pairs: writes even-row pair sums to the line buffer, or reads
// them back, finishes the 2x2 sums and builds the tiled destination address.
// ----------------------------------------------------------------------------
module mipbox_back #(
  parameter int MAX_WIDTH = mipbox_pkg::MAX_WIDTH_DEF,
  parameter int TILE_SIZE = mipbox_pkg::TILE_SIZE_DEF,
  parameter int CHANNELS  = mipbox_pkg::CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  input  logic [mipbox_pkg::item_w(MAX_WIDTH, TILE_SIZE)-1:0] q_item,
  output logic                                   q_pop,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]         w,
  input  logic [mipbox_pkg::ADDR_W-1:0]          level_offset,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [mipbox_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                   m_tlast
);
  import mipbox_pkg::*;

  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = bits_for(LINE_DEPTH);
  localparam int TI_W       = bits_for(TILE_SIZE);
  localparam int IN_W       = bits_for(TILE_SIZE * TILE_SIZE);
  // tiles per row by reciprocal multiply, exact for every numerator below 2**N
  localparam int N          = $clog2(MAX_WIDTH / 2 + TILE_SIZE);
  localparam int L          = $clog2(TILE_SIZE);
  localparam int RECIP      = ((1 << (N + L)) + TILE_SIZE - 1) / TILE_SIZE;
  localparam int QP_W       = 2 * N + 1;
  localparam int PROD_W     = OY_W + N;

  mb_ctl_t          it_ctl;
  logic [IDX_W-1:0] it_idx;
  pair_vec_t        it_pair;
  logic [OY_W-1:0]  it_tile_row;
  logic [IDX_W-1:0] it_tile_col;
  logic [TI_W-1:0]  it_oy_in;
  logic [TI_W-1:0]  it_ox_in;

  logic [N-1:0]    num;
  logic [QP_W-1:0] qprod;
  logic [N-1:0]    tpr;

  logic      adv;
  logic      ram_we;
  logic      ram_re;
  pair_vec_t ram_rdata;

  logic             s1_valid;
  pair_vec_t        s1_pair;
  logic             s1_last;
  logic [PROD_W-1:0] s1_prod;
  logic [IDX_W-1:0] s1_tile_col;
  logic [IN_W-1:0]  s1_inner;

  logic                             s2_valid;
  logic [CHAN_NUM-1:0][SUM_W-1:0]   s2_sum;
  logic                             s2_last;
  logic [ADDR_W-1:0]                s2_tidx;
  logic [IN_W-1:0]                  s2_inner;

  pix_vec_t          out_avg;
  logic [ADDR_W-1:0] out_addr;

  assign {it_ctl, it_idx, it_pair, it_tile_row, it_tile_col, it_oy_in, it_ox_in} = q_item;

  assign num   = N'(w >> 1) + N'(TILE_SIZE - 1);
  assign qprod = QP_W'(num) * QP_W'(RECIP);

  always_ff @(posedge clk) begin
    tpr <= N'(qprod >> (N + L));
  end

  assign adv    = !m_tvalid || m_tready;
  assign q_pop  = adv && !q_empty;
  assign ram_we = q_pop && !it_ctl.emit;
  assign ram_re = q_pop && it_ctl.emit;

  mipbox_ram #(
    .WIDTH ($bits(pair_vec_t)),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (it_idx),
    .wdata (it_pair),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= ram_re;
      s2_valid <= s1_valid;
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pair     <= it_pair;
      s1_last     <= it_ctl.last;
      s1_prod     <= PROD_W'(PROD_W'(it_tile_row) * PROD_W'(tpr));
      s1_tile_col <= it_tile_col;
      s1_inner    <= IN_W'(32'(it_oy_in) * TILE_SIZE + 32'(it_ox_in));

      for (int c = 0; c < CHAN_NUM; c++) begin
        s2_sum[c] <= SUM_W'(ram_rdata[c]) + SUM_W'(s1_pair[c]);
      end
      s2_last  <= s1_last;
      s2_tidx  <= ADDR_W'(s1_prod) + ADDR_W'(s1_tile_col);
      s2_inner <= s1_inner;

      for (int c = 0; c < CHAN_NUM; c++) begin
        out_avg[c] <= (c < CHANNELS) ? s2_sum[c][SUM_W-1:2] : '0;
      end
      out_addr <= level_offset + ADDR_W'(s2_tidx * ADDR_W'(TILE_SIZE * TILE_SIZE))
                  + ADDR_W'(s2_inner);
      m_tlast  <= s2_last;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_addr, out_avg});

  a_read_before_s1: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && $past(adv)) |-> $past(ram_re))
    else $error("stage one valid without a line buffer read");
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !adv) |=> (s2_valid && $stable(s2_sum) && $stable(s2_tidx)))
    else $error("stage two changed while stalled");

endmodule
